// ----- src/encoder_jog_stepper_controller_assert.svh -----
// ----------------------------------------------------------------------------
// Encoder jog stepper controller assertion macros
// Shared concurrent assertion forms, sampled on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ENCODER_JOG_STEPPER_CONTROLLER_ASSERT_SVH
`define ENCODER_JOG_STEPPER_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define EJSC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ejsc: same-cycle check failed");

// next-cycle implication
`define EJSC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ejsc: next-cycle check failed");

`endif

// ----- src/ejsc_pkg.sv -----
// ----------------------------------------------------------------------------
// ejsc_pkg
// Types, register indexes and reset values of the encoder jog stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package ejsc_pkg;

   localparam int COUNT_WIDTH_DEF = 16;

   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_UNIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_HALF_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_TICKS    = 2'd3;

   localparam logic [15:0] SPU_RST      = 16'd1600;
   localparam logic [7:0]  HALF_RST     = 8'd2;
   localparam logic [9:0]  DEBOUNCE_RST = 10'd50;
   localparam logic [15:0] SETTLE_RST   = 16'd1000;

   localparam int PRESS_W     = 11;
   localparam int STEP_CNT_W  = 32;

   localparam logic [1:0] STATUS_IDLE    = 2'd0;
   localparam logic [1:0] STATUS_ADVANCE = 2'd1;
   localparam logic [1:0] STATUS_RETRACT = 2'd2;

   typedef struct packed {
      logic [15:0] steps_per_unit;
      logic [7:0]  step_half_ticks;
      logic [9:0]  debounce_ticks;
      logic [15:0] settle_ticks;
   } cfg_type;

   typedef struct packed {
      logic               step_out;
      logic               dir_out;
      logic [1:0]         motor_status;
      logic signed [15:0] position_count;
      logic               busy_res;
   } res_type;

endpackage

`default_nettype wire

// ----- src/ejsc_core.sv -----
// ----------------------------------------------------------------------------
// ejsc_core
// Per-tick state update: encoder count, button debounce, step pulse timing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "encoder_jog_stepper_controller_assert.svh"

module ejsc_core #(
   parameter int COUNT_WIDTH = ejsc_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             tick_en,
   input  wire logic             enc_a,
   input  wire logic             enc_b,
   input  wire logic             button_n,
   input  wire ejsc_pkg::cfg_type cfg,
   output ejsc_pkg::res_type     res
);

   localparam int PROD_W = COUNT_WIDTH + 16;
   localparam int EXT_W  = 48;

   typedef enum logic [1:0] {PH_IDLE, PH_STEP, PH_SETTLE} phase_type;

   localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
   localparam logic signed [COUNT_WIDTH-1:0] CNT_RST = '1;

   phase_type                          phase_ff, phase_in;
   logic                               prev_a_ff, prev_a_in;
   logic signed [COUNT_WIDTH-1:0]      count_ff, count_in;
   logic [ejsc_pkg::PRESS_W-1:0]       press_ff, press_in;
   logic [ejsc_pkg::STEP_CNT_W-1:0]    steps_ff, steps_in;
   logic [7:0]                         half_ff, half_in;
   logic                               step_ff, step_in;
   logic                               dir_ff, dir_in;
   logic [15:0]                        settle_ff, settle_in;
   logic [COUNT_WIDTH-1:0]             mag_ff, mag_in;
   logic [15:0]                        spu_ff, spu_in;
   logic                               pend_ff, pend_in;

   logic [7:0]                         half_reload;
   logic [7:0]                         half_dec;
   logic [15:0]                        settle_dec;
   logic [PROD_W-1:0]                  prod;
   logic [EXT_W-1:0]                   prod_ext;
   logic [ejsc_pkg::STEP_CNT_W-1:0]    prod_sat;

   assign half_reload = (cfg.step_half_ticks == 8'd0) ? 8'd1 : cfg.step_half_ticks;
   assign half_dec    = (half_ff != 8'd0) ? half_ff - 8'd1 : 8'd0;
   assign settle_dec  = (settle_ff != 16'd0) ? settle_ff - 16'd1 : 16'd0;

   // pulse count is loaded via pend_ff in the cycle after the move starts
   assign prod     = PROD_W'(mag_ff) * PROD_W'(spu_ff);
   assign prod_ext = EXT_W'(prod);
   assign prod_sat = (|prod_ext[EXT_W-1:ejsc_pkg::STEP_CNT_W]) ? '1
                                                               : prod_ext[31:0];

   always_comb begin
      phase_in  = phase_ff;
      prev_a_in = prev_a_ff;
      count_in  = count_ff;
      press_in  = press_ff;
      steps_in  = steps_ff;
      half_in   = half_ff;
      step_in   = step_ff;
      dir_in    = dir_ff;
      settle_in = settle_ff;
      mag_in    = mag_ff;
      spu_in    = spu_ff;
      pend_in   = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (enc_a && !prev_a_ff) begin
               if (enc_b != enc_a) begin
                  if (count_ff != CNT_MIN) count_in = count_ff - 1'b1;
               end else begin
                  if (count_ff != CNT_MAX) count_in = count_ff + 1'b1;
               end
            end
            prev_a_in = enc_a;
            if (!button_n) begin
               press_in = '0;
               if (press_ff > {1'b0, cfg.debounce_ticks}) begin
                  dir_in = count_in[COUNT_WIDTH-1];
                  mag_in = count_in[COUNT_WIDTH-1] ? COUNT_WIDTH'(-count_in)
                                                   : COUNT_WIDTH'(count_in);
                  spu_in = cfg.steps_per_unit;
                  if (count_in != '0 && cfg.steps_per_unit != 16'd0) begin
                     phase_in = PH_STEP;
                     step_in  = 1'b1;
                     half_in  = half_reload;
                     pend_in  = 1'b1;
                  end else begin
                     step_in = 1'b0;
                     if (cfg.settle_ticks == 16'd0) begin
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in  = PH_SETTLE;
                        settle_in = cfg.settle_ticks;
                     end
                  end
               end
            end else if (press_ff != '1) begin
               press_in = press_ff + 1'b1;
            end
         end
         PH_STEP: begin
            half_in = half_dec;
            if (half_dec == 8'd0) begin
               if (step_ff) begin
                  step_in = 1'b0;
                  half_in = half_reload;
               end else if (steps_ff > 32'd1) begin
                  steps_in = steps_ff - 1'b1;
                  step_in  = 1'b1;
                  half_in  = half_reload;
               end else begin
                  steps_in = '0;
                  step_in  = 1'b0;
                  if (cfg.settle_ticks == 16'd0) begin
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in  = PH_SETTLE;
                     settle_in = cfg.settle_ticks;
                  end
               end
            end
         end
         PH_SETTLE: begin
            settle_in = settle_dec;
            if (settle_dec == 16'd0) phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      res.step_out       = step_in;
      res.dir_out        = dir_in;
      res.motor_status   = (phase_in != PH_STEP) ? ejsc_pkg::STATUS_IDLE
                         : dir_in ? ejsc_pkg::STATUS_RETRACT
                         : ejsc_pkg::STATUS_ADVANCE;
      res.position_count = 16'(count_in);
      res.busy_res       = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         prev_a_ff <= 1'b1;
         count_ff  <= CNT_RST;
         press_ff  <= '1;
         steps_ff  <= '0;
         half_ff   <= '0;
         step_ff   <= 1'b0;
         dir_ff    <= 1'b0;
         settle_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         pend_ff <= tick_en & pend_in;
         if (pend_ff) begin
            steps_ff <= prod_sat;
         end else if (tick_en) begin
            steps_ff <= steps_in;
         end
         if (tick_en) begin
            phase_ff  <= phase_in;
            prev_a_ff <= prev_a_in;
            count_ff  <= count_in;
            press_ff  <= press_in;
            half_ff   <= half_in;
            step_ff   <= step_in;
            dir_ff    <= dir_in;
            settle_ff <= settle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick_en) begin
         mag_ff <= mag_in;
         spu_ff <= spu_in;
      end
   end

   `EJSC_ASSERT_NOW(a_settle_low, phase_ff == PH_SETTLE, !step_ff)
   `EJSC_ASSERT_NEXT(a_busy_count, tick_en && phase_ff != PH_IDLE, count_ff == $past(count_ff))
   `EJSC_ASSERT_NEXT(a_load_once, pend_ff, !pend_ff && phase_ff != PH_IDLE)

endmodule

`default_nettype wire

// ----- src/encoder_jog_stepper_controller.sv -----
// ----------------------------------------------------------------------------
// encoder_jog_stepper_controller
// Quadrature jog counter driving a step/direction pulse generator.
// ----------------------------------------------------------------------------
// Result: an accepted tick word has its result word registered in res_ff.
// Throughput: one tick word per cycle; a full result register stalls req only
// when rsp_ready is low.
// Reset: synchronous; clears count to -1, motion to idle, registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_jog_stepper_controller #(
   parameter int COUNT_WIDTH = ejsc_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_enc_a,
   input  wire logic                              req_enc_b,
   input  wire logic                              req_button_n,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_step_out,
   output logic                                   rsp_dir_out,
   output logic [1:0]                             rsp_motor_status,
   output logic signed [15:0]                     rsp_position_count,
   output logic                                   rsp_busy_res,
   input  wire logic                              csr_wen,
   input  wire logic [ejsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ejsc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ejsc_pkg::cfg_type cfg_ff;
   ejsc_pkg::res_type res_next;
   ejsc_pkg::res_type res_ff;
   logic              rsp_valid_ff;
   logic              tick_en;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign tick_en   = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps_per_unit  <= ejsc_pkg::SPU_RST;
         cfg_ff.step_half_ticks <= ejsc_pkg::HALF_RST;
         cfg_ff.debounce_ticks  <= ejsc_pkg::DEBOUNCE_RST;
         cfg_ff.settle_ticks    <= ejsc_pkg::SETTLE_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            ejsc_pkg::CSR_STEPS_PER_UNIT:  cfg_ff.steps_per_unit  <= csr_wdata;
            ejsc_pkg::CSR_STEP_HALF_TICKS: cfg_ff.step_half_ticks <= csr_wdata[7:0];
            ejsc_pkg::CSR_DEBOUNCE_TICKS:  cfg_ff.debounce_ticks  <= csr_wdata[9:0];
            ejsc_pkg::CSR_SETTLE_TICKS:    cfg_ff.settle_ticks    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   ejsc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .tick_en  (tick_en),
      .enc_a    (req_enc_a),
      .enc_b    (req_enc_b),
      .button_n (req_button_n),
      .cfg      (cfg_ff),
      .res      (res_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_en) begin
         res_ff <= res_next;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_out       = res_ff.step_out;
   assign rsp_dir_out        = res_ff.dir_out;
   assign rsp_motor_status   = res_ff.motor_status;
   assign rsp_position_count = res_ff.position_count;
   assign rsp_busy_res       = res_ff.busy_res;

endmodule

`default_nettype wire
